// ----- design/ttw_pkg.sv -----
// shared types and constants for the text terminal writer
// no dependencies; imported by ttw_ctrl, ttw_dp and text_terminal_writer_unit
package ttw_pkg;

    localparam int CHAR_W     = 8;
    localparam int ATTR_W     = 8;
    localparam int CELL_W     = 16;
    localparam int IDX_W      = 11;
    localparam int OUT_ROW_W  = 5;
    localparam int OUT_COL_W  = 7;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;
    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'd79;

    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_COPY,
        ST_FILL
    } t_state;

    typedef enum logic [1:0] {
        LD_NONE,
        LD_PUT,
        LD_READ,
        LD_SCROLL
    } t_load;

    typedef struct packed {
        logic  put;
        logic  rd;
        logic  copy;
        logic  fill;
        logic  clear;
        t_load load;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic put_scrolls;
        logic copy_last;
        logic fill_done;
        logic clear_done;
    } t_stat;

endpackage

// ----- design/text_terminal_writer_unit.sv -----
// top level of the text terminal writer: stream ports, attribute register port
// depends on ttw_pkg, ttw_ctrl and ttw_dp
// results: a plain put loads the result register as it is accepted; a read goes
//   via the memory read register and ST_READ; a scroll runs ST_COPY then ST_FILL
// throughput: one put per cycle while out_free holds; reads and scrolls hold off
//   requests. reset: synchronous active low, then a clearing pass writes spaces
//   in attribute 79 to every cell while no request is accepted
module text_terminal_writer_unit #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // attribute register write
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // char_code [7:0], cell_index [18:8], zero [23:19]
    input  logic        s_axis_tuser,   // op
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // cell_data [15:0], cursor_row [20:16],
                                        // cursor_col [27:21], scrolled [28], zero [31:29]
);
    import ttw_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    logic [CELL_W-1:0]    cell_data;
    logic [OUT_ROW_W-1:0] cursor_row;
    logic [OUT_COL_W-1:0] cursor_col;
    logic                 scrolled;

    // state machine: clear pass, idle, read wait, row copy, last row fill
    ttw_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_s_op    (s_axis_tuser),
        .i_stat    (stat),
        .o_s_ready (s_axis_tready),
        .o_cmd     (cmd)
    );

    // screen memory, cursor and result register
    ttw_dp #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_char_code  (s_axis_tdata[7:0]),
        .i_cell_index (s_axis_tdata[18:8]),
        .i_m_ready    (m_axis_tready),
        .o_m_valid    (m_axis_tvalid),
        .o_cell_data  (cell_data),
        .o_cursor_row (cursor_row),
        .o_cursor_col (cursor_col),
        .o_scrolled   (scrolled)
    );

    // pack result fields, lowest field first
    assign m_axis_tdata = {3'b000, scrolled, cursor_col, cursor_row, cell_data};

endmodule

// ----- design/ttw_ctrl.sv -----
// controller state machine of the text terminal writer
// depends on ttw_pkg; drives the command struct into ttw_dp
module ttw_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_valid,
    input  logic          i_s_op,
    input  ttw_pkg::t_stat i_stat,
    output logic          o_s_ready,
    output ttw_pkg::t_cmd o_cmd
);
    import ttw_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_s_ready  = 1'b0;
        o_cmd      = '{put: 1'b0, rd: 1'b0, copy: 1'b0, fill: 1'b0, clear: 1'b0,
                       load: LD_NONE};
        accept     = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_stat.clear_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_s_ready = i_stat.out_free;
                accept    = i_s_valid && i_stat.out_free;
                if (accept) begin
                    if (i_s_op == OP_READ) begin
                        o_cmd.rd = 1'b1;
                        n_state  = ST_READ;
                    end else begin
                        o_cmd.put = 1'b1;
                        if (i_stat.put_scrolls) begin
                            n_state = ST_COPY;
                        end else begin
                            o_cmd.load = LD_PUT;
                        end
                    end
                end
            end
            ST_READ: begin
                o_cmd.load = LD_READ;
                n_state    = ST_IDLE;
            end
            ST_COPY: begin
                o_cmd.copy = 1'b1;
                if (i_stat.copy_last) begin
                    n_state = ST_FILL;
                end
            end
            ST_FILL: begin
                o_cmd.fill = 1'b1;
                if (i_stat.fill_done) begin
                    o_cmd.load = LD_SCROLL;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

endmodule

// ----- design/ttw_dp.sv -----
// datapath of the text terminal writer: screen memory, cursor, scan counter, output register
// depends on ttw_pkg; commanded by ttw_ctrl
module ttw_dp #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ttw_pkg::t_cmd                 i_cmd,
    output ttw_pkg::t_stat                o_stat,
    input  logic                          i_cfg_we,
    input  logic [ttw_pkg::ATTR_W-1:0]    i_cfg_wdata,
    input  logic [ttw_pkg::CHAR_W-1:0]    i_char_code,
    input  logic [ttw_pkg::IDX_W-1:0]     i_cell_index,
    input  logic                          i_m_ready,
    output logic                          o_m_valid,
    output logic [ttw_pkg::CELL_W-1:0]    o_cell_data,
    output logic [ttw_pkg::OUT_ROW_W-1:0] o_cursor_row,
    output logic [ttw_pkg::OUT_COL_W-1:0] o_cursor_col,
    output logic                          o_scrolled
);
    import ttw_pkg::*;

    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int AW         = $clog2(CELL_COUNT);
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int ROW_W      = $clog2(ROWS);

    localparam logic [AW-1:0]    CELL_LAST  = AW'(CELL_COUNT - 1);
    localparam logic [AW-1:0]    COPY_LAST  = AW'(CELL_COUNT - COLUMNS - 1);
    localparam logic [AW-1:0]    ROW_STEP   = AW'(COLUMNS);
    localparam logic [COL_W-1:0] COL_LAST   = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0] ROW_LAST   = ROW_W'(ROWS - 1);
    localparam logic [CELL_W-1:0] RESET_CELL = {ATTR_RESET, SPACE_CODE};

    logic [CELL_W-1:0] mem [CELL_COUNT];

    logic [CELL_W-1:0] r_rdata;
    logic              r_rd_ok;
    logic [AW-1:0]     r_scan;
    logic [AW-1:0]     r_dst;
    logic              r_wr_pend;
    logic [ATTR_W-1:0] r_attr;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  r_col, n_col;
    logic [AW-1:0]     r_base, n_base;

    logic                 r_out_valid;
    logic [CELL_W-1:0]    r_out_data;
    logic [OUT_ROW_W-1:0] r_out_row;
    logic [OUT_COL_W-1:0] r_out_col;
    logic                 r_out_scrolled;

    logic              we;
    logic [AW-1:0]     waddr;
    logic [CELL_W-1:0] wdata;
    logic              re;
    logic [AW-1:0]     raddr;
    logic              fill_en;
    logic              scan_last;
    logic              wrap;
    logic [31:0]       idx32;
    logic [31:0]       row32;
    logic [31:0]       col32;

    assign idx32     = 32'(i_cell_index);
    assign scan_last = (r_scan == CELL_LAST);
    assign fill_en   = i_cmd.fill && !r_wr_pend;
    assign wrap      = (i_char_code == NEWLINE_CODE) || (r_col == COL_LAST);

    // cursor after a put
    always_comb begin
        n_row  = r_row;
        n_col  = r_col;
        n_base = r_base;
        if (i_cmd.put) begin
            if (!wrap) begin
                n_col = r_col + 1'b1;
            end else begin
                n_col = '0;
                if (r_row != ROW_LAST) begin
                    n_row  = r_row + 1'b1;
                    n_base = r_base + ROW_STEP;
                end
            end
        end
    end

    assign o_stat.out_free    = !r_out_valid || i_m_ready;
    assign o_stat.put_scrolls = wrap && (r_row == ROW_LAST);
    assign o_stat.copy_last   = (r_scan == COPY_LAST);
    assign o_stat.fill_done   = fill_en && scan_last;
    assign o_stat.clear_done  = scan_last;

    // single write port: pending copy first, then clear, fill, put
    always_comb begin
        we    = 1'b0;
        waddr = r_scan;
        wdata = RESET_CELL;
        if (r_wr_pend) begin
            we    = 1'b1;
            waddr = r_dst;
            wdata = r_rdata;
        end else if (i_cmd.clear) begin
            we = 1'b1;
        end else if (fill_en) begin
            we    = 1'b1;
            wdata = {r_attr, SPACE_CODE};
        end else if (i_cmd.put && (i_char_code != NEWLINE_CODE)) begin
            we    = 1'b1;
            waddr = r_base + AW'(r_col);
            wdata = {r_attr, i_char_code};
        end
    end

    always_comb begin
        re    = i_cmd.rd || i_cmd.copy;
        raddr = i_cmd.rd ? idx32[AW-1:0] : r_scan + ROW_STEP;
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            r_rdata <= mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_ok <= (idx32 < 32'(CELL_COUNT));
        end
        r_dst <= r_scan;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan    <= '0;
            r_wr_pend <= 1'b0;
            r_attr    <= ATTR_RESET;
            r_row     <= '0;
            r_col     <= '0;
            r_base    <= '0;
        end else begin
            r_wr_pend <= i_cmd.copy;
            if (i_cmd.clear || fill_en) begin
                r_scan <= scan_last ? '0 : r_scan + 1'b1;
            end else if (i_cmd.copy) begin
                r_scan <= r_scan + 1'b1;
            end
            if (i_cfg_we) begin
                r_attr <= i_cfg_wdata;
            end
            r_row  <= n_row;
            r_col  <= n_col;
            r_base <= n_base;
        end
    end

    assign row32 = 32'(n_row);
    assign col32 = 32'(n_col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load != LD_NONE) begin
            r_out_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load != LD_NONE) begin
            r_out_data     <= (i_cmd.load == LD_READ && r_rd_ok) ? r_rdata : '0;
            r_out_row      <= row32[OUT_ROW_W-1:0];
            r_out_col      <= col32[OUT_COL_W-1:0];
            r_out_scrolled <= (i_cmd.load == LD_SCROLL);
        end
    end

    assign o_m_valid    = r_out_valid;
    assign o_cell_data  = r_out_data;
    assign o_cursor_row = r_out_row;
    assign o_cursor_col = r_out_col;
    assign o_scrolled   = r_out_scrolled;

`ifndef SYNTH
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load != LD_NONE) |-> (!r_out_valid || i_m_ready))
        else $error("result loaded over an unread result");

    a_base_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_base == AW'(32'(r_row) * COLUMNS))
        else $error("row base out of step with cursor row");

    a_scroll_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.put && o_stat.put_scrolls) |=> ($stable(r_row) && $stable(r_base)))
        else $error("cursor row moved on a scrolling put");

    a_no_write_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr_pend |-> !(i_cmd.put || i_cmd.clear))
        else $error("copy write collides with another write");
`endif

endmodule

// ----- sim/ttw_checker.sv -----
`timescale 1ns / 1ps
// checker for the text terminal writer: keeps its own screen and cursor copy,
// predicts one report per request and compares it with the result stream; uses ttw_pkg
module ttw_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [23:0] i_req_data,    // char_code [7:0], cell_index [18:8], zero [23:19]
    input  logic        i_req_user,    // op
    input  logic        i_rsp_valid,
    input  logic        i_rsp_ready,
    input  logic [31:0] i_rsp_data,    // cell_data [15:0], cursor_row [20:16],
                                       // cursor_col [27:21], scrolled [28], zero [31:29]
    output int          o_mismatches,
    output int          o_outstanding
);
    import ttw_pkg::*;

    localparam int CELLS = ROWS * COLUMNS;

    typedef struct packed {
        logic                 scrolled;
        logic [OUT_COL_W-1:0] col;
        logic [OUT_ROW_W-1:0] row;
        logic [CELL_W-1:0]    cell_word;
    } t_report;

    logic [CELL_W-1:0] screen [CELLS];
    int unsigned       row_pos;
    int unsigned       col_pos;
    logic [ATTR_W-1:0] text_attr;
    t_report           expected_reports [$];
    int                mismatch_count = 0;

    // cursor to the next line; scroll the screen when it runs off the bottom
    task automatic line_feed(output logic scrolled);
        scrolled = 1'b0;
        row_pos++;
        if (row_pos >= ROWS) begin
            for (int i = 0; i < CELLS - COLUMNS; i++)
                screen[i] = screen[i + COLUMNS];
            for (int i = CELLS - COLUMNS; i < CELLS; i++)
                screen[i] = {text_attr, SPACE_CODE};
            row_pos  = ROWS - 1;
            scrolled = 1'b1;
        end
    endtask

    task automatic terminal_step(input logic op, input logic [CHAR_W-1:0] ch,
                                 input logic [IDX_W-1:0] idx, output t_report rep);
        logic        scr;
        int unsigned pos;
        scr = 1'b0;
        rep = '0;
        if (op == OP_READ) begin
            if (idx < CELLS)
                rep.cell_word = screen[idx];
        end else if (ch == NEWLINE_CODE) begin
            col_pos = 0;
            line_feed(scr);
        end else begin
            pos = row_pos * COLUMNS + col_pos;
            if (pos < CELLS)
                screen[pos] = {text_attr, ch};
            col_pos++;
            if (col_pos >= COLUMNS) begin
                col_pos = 0;
                line_feed(scr);
            end
        end
        rep.row      = row_pos[OUT_ROW_W-1:0];
        rep.col      = col_pos[OUT_COL_W-1:0];
        rep.scrolled = scr;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s expected %0h actual %0h", $realtime, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_report got;
        t_report want;
        t_report fresh;
        if (!i_rst_n) begin
            for (int i = 0; i < CELLS; i++)
                screen[i] = {ATTR_RESET, SPACE_CODE};
            row_pos   = 0;
            col_pos   = 0;
            text_attr = ATTR_RESET;
            expected_reports.delete();
        end else begin
            if (i_rsp_valid && i_rsp_ready) begin
                got = i_rsp_data[28:0];
                if (expected_reports.size() == 0) begin
                    $display("%0t: result expected none actual %0h", $realtime, got);
                    mismatch_count++;
                end else begin
                    want = expected_reports.pop_front();
                    check_field("cell_data", want.cell_word, got.cell_word);
                    check_field("cursor_row", want.row, got.row);
                    check_field("cursor_col", want.col, got.col);
                    check_field("scrolled", want.scrolled, got.scrolled);
                end
            end
            if (i_cfg_we)
                text_attr = i_cfg_wdata;
            if (i_req_valid && i_req_ready) begin
                terminal_step(i_req_user, i_req_data[7:0], i_req_data[18:8], fresh);
                expected_reports.push_back(fresh);
            end
        end
        o_mismatches  = mismatch_count;
        o_outstanding = expected_reports.size();
    end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// top of the text terminal writer bench: clock, reset, request and result traffic,
// attribute writes and the verdict; depends on ttw_pkg, ttw_checker and the block
module tb;
    import ttw_pkg::*;

    localparam int COLUMNS      = 80;
    localparam int ROWS         = 25;
    localparam int CELLS        = ROWS * COLUMNS;
    // longest quiet stretch is the clearing pass or one scroll
    localparam int STALL_LIMIT  = 10 * CELLS;
    localparam int PHASE_ITEMS  = 306;
    localparam int PHASE_COUNT  = 5;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [7:0]  i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;     // char_code [7:0], cell_index [18:8], zero [23:19]
    logic        s_axis_tuser;     // op
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;     // cell_data [15:0], cursor_row [20:16],
                                   // cursor_col [27:21], scrolled [28], zero [31:29]
    int          mismatches;
    int          outstanding;
    int          quiet_cycles = 0;

    text_terminal_writer_unit #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    ttw_checker #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_req_valid   (s_axis_tvalid),
        .i_req_ready   (s_axis_tready),
        .i_req_data    (s_axis_tdata),
        .i_req_user    (s_axis_tuser),
        .i_rsp_valid   (m_axis_tvalid),
        .i_rsp_ready   (m_axis_tready),
        .i_rsp_data    (m_axis_tdata),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    // 8 ns clock
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // watchdog: ends the run when neither channel moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // idle length: mostly short, now and then a long one
    function automatic int idle_length();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result side: random back-pressure, with some long ready stretches
    initial begin
        int hold;
        int pick;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                m_axis_tready = 1'b1;
                hold = 200;
            end else if (pick < 60) begin
                m_axis_tready = 1'b1;
                hold = $urandom_range(1, 30);
            end else begin
                m_axis_tready = 1'b0;
                hold = idle_length();
            end
            repeat (hold - 1) @(negedge i_clk);
        end
    end

    // one request: drive at the falling edge, hold until accepted, then maybe a gap
    task automatic send_request(input logic op, input logic [CHAR_W-1:0] ch,
                                input logic [IDX_W-1:0] idx);
        int gap;
        gap = $urandom_range(0, 1) ? 0 : idle_length();
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = op;
        s_axis_tdata  = {5'b0, idx, ch};
        do @(posedge i_clk); while (!s_axis_tready);
        // valid stays high on a zero gap so back-to-back requests keep it up
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // stop sending and wait until every report has come back
    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (outstanding != 0) @(negedge i_clk);
    endtask

    // attribute write only with the block idle
    task automatic set_attribute(input logic [ATTR_W-1:0] value);
        wait_drained();
        repeat (4) @(negedge i_clk);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    initial begin
        int               pick;
        int               sub;
        logic [IDX_W-1:0] idx;
        logic [ATTR_W-1:0] attr;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_PUT;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        // clearing pass after reset, nothing is accepted meanwhile
        repeat (CELLS + 100) @(negedge i_clk);

        // reset contents, corners and reads past the screen
        send_request(OP_READ, 8'h00, 11'd0);
        send_request(OP_READ, 8'hFF, 11'(CELLS - 1));
        send_request(OP_READ, 8'h00, 11'(CELLS));
        send_request(OP_READ, 8'h00, 11'h7FF);
        send_request(OP_READ, 8'h00, 11'd1024);
        // extreme characters, a newline, then read them back
        send_request(OP_PUT, 8'h48, 11'h7FF);
        send_request(OP_PUT, 8'h00, 11'd0);
        send_request(OP_PUT, 8'hFF, 11'd0);
        send_request(OP_PUT, NEWLINE_CODE, 11'd0);
        send_request(OP_PUT, 8'h7F, 11'd0);
        send_request(OP_READ, 8'h00, 11'd0);
        send_request(OP_READ, 8'h00, 11'd1);
        send_request(OP_READ, 8'h00, 11'd2);
        send_request(OP_READ, 8'h00, 11'(COLUMNS));
        // new attribute must leave earlier cells alone
        set_attribute(8'hA5);
        send_request(OP_PUT, 8'h41, 11'd0);
        send_request(OP_READ, 8'h00, 11'd0);
        send_request(OP_READ, 8'h00, 11'(COLUMNS + 1));

        // random phases, each with its own attribute, extremes included
        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0: attr = 8'h00;
                1: attr = 8'hFF;
                3: attr = 8'h1E;
                default: attr = 8'($urandom_range(0, 255));
            endcase
            set_attribute(attr);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 45) begin
                    // reads: whole screen, bottom rows where text lands, past the end
                    sub = $urandom_range(0, 9);
                    if (sub < 7)
                        idx = 11'($urandom_range(0, CELLS - 1));
                    else if (sub < 9)
                        idx = 11'($urandom_range(CELLS - 2 * COLUMNS, CELLS - 1));
                    else
                        idx = 11'($urandom_range(CELLS, 2047));
                    send_request(OP_READ, 8'($urandom_range(0, 255)), idx);
                end else if (pick < 51) begin
                    // newlines drive the cursor down and scroll the screen at the bottom
                    send_request(OP_PUT, NEWLINE_CODE, 11'($urandom_range(0, 2047)));
                end else begin
                    send_request(OP_PUT, 8'($urandom_range(0, 255)),
                                 11'($urandom_range(0, 2047)));
                end
                // occasional full drain in the middle of traffic
                if ($urandom_range(0, 199) == 0)
                    wait_drained();
            end
        end

        // drain, then leave room for any stray result
        wait_drained();
        repeat (CELLS + 10) @(negedge i_clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
